>>> design/lfp_pkg.sv
`timescale 1ns / 1ps

package lfp_pkg;

    localparam logic [7:0]  HEADER_RESET  = 8'h59;
    localparam logic [16:0] TEMP_OFFSET   = 17'd2048;
    localparam int          MID_DEPTH_DEF = 2;
    localparam int          OUT_DEPTH_DEF = 2;

    // classified byte handed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       is_header;
    } lfp_item_t;

    // one decoded frame
    typedef struct packed {
        logic [15:0]        distance;
        logic [15:0]        strength;
        logic signed [16:0] temperature_eighths;
        logic               checksum_ok;
    } lfp_result_t;

endpackage

>>> design/lidar_frame_parser.sv
`timescale 1ns / 1ps

// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+------------------------------------------
// byte in   | in        | push / full          | data_byte[7:0]
// result    | out       | pop / empty          | distance, strength, temperature_eighths,
//           |           |                      | checksum_ok
// config    | in        | cfg_we               | cfg_wdata[7:0] (header byte)
//
// One byte per cycle sustained; a byte beat is taken whenever full is low.
// A frame's checksum byte is written to the front queue; when the back takes it
// from there, the frame's result is written to the result queue for the result ports.
// Reset (rst_n low, async) empties both queues, enters header hunt, loads 0x59.
// With the result queue full, only a checksum byte stalls; the front queue
// keeps taking bytes until it fills too, then full rises.

module lidar_frame_parser #(
    parameter int MID_DEPTH = lfp_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH = lfp_pkg::OUT_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         data_byte,
    output logic               empty,
    input  logic               pop,
    output logic [15:0]        distance,
    output logic [15:0]        strength,
    output logic signed [16:0] temperature_eighths,
    output logic               checksum_ok
);

    import lfp_pkg::*;

    lfp_item_t   item;
    logic        item_valid;
    logic        item_take;
    lfp_result_t result;

    // front: header register, byte classification, decoupling queue
    lfp_front #(
        .MID_DEPTH (MID_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .push       (push),
        .data_byte  (data_byte),
        .full       (full),
        .item       (item),
        .item_valid (item_valid),
        .item_take  (item_take)
    );

    // back: phase machine, running checksum, field assembly, result queue
    lfp_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .result     (result),
        .empty      (empty),
        .pop        (pop)
    );

    assign distance            = result.distance;
    assign strength            = result.strength;
    assign temperature_eighths = result.temperature_eighths;
    assign checksum_ok         = result.checksum_ok;

endmodule

>>> design/lfp_fifo.sv
`timescale 1ns / 1ps

module lfp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> design/lfp_front.sv
`timescale 1ns / 1ps

module lfp_front #(
    parameter int MID_DEPTH = lfp_pkg::MID_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_wdata,
    input  logic              push,
    input  logic [7:0]        data_byte,
    output logic              full,
    output lfp_pkg::lfp_item_t item,
    output logic              item_valid,
    input  logic              item_take
);

    import lfp_pkg::*;

    logic [7:0] header_reg;
    lfp_item_t  cls_item;
    logic       mid_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= HEADER_RESET;
        end
        else if (cfg_we)
        begin
            header_reg <= cfg_wdata;
        end
    end

    // header compare uses the register value at the time the byte arrives
    always_comb
    begin
        cls_item.data      = data_byte;
        cls_item.is_header = (data_byte == header_reg);
    end

    lfp_fifo #(
        .WIDTH ($bits(lfp_item_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cls_item),
        .full    (full),
        .rd_en   (item_take),
        .rd_data (item),
        .empty   (mid_empty)
    );

    assign item_valid = !mid_empty;

endmodule

>>> design/lfp_back.sv
`timescale 1ns / 1ps

module lfp_back #(
    parameter int OUT_DEPTH = lfp_pkg::OUT_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lfp_pkg::lfp_item_t  item,
    input  logic                item_valid,
    output logic                item_take,
    output lfp_pkg::lfp_result_t result,
    output logic                empty,
    input  logic                pop
);

    import lfp_pkg::*;

    localparam logic [3:0] PH_HUNT    = 4'd0;
    localparam logic [3:0] PH_HDR2    = 4'd1;
    localparam logic [3:0] PH_DIST_LO = 4'd2;
    localparam logic [3:0] PH_DIST_HI = 4'd3;
    localparam logic [3:0] PH_STR_LO  = 4'd4;
    localparam logic [3:0] PH_STR_HI  = 4'd5;
    localparam logic [3:0] PH_TEMP_LO = 4'd6;
    localparam logic [3:0] PH_TEMP_HI = 4'd7;
    localparam logic [3:0] PH_CKSUM   = 4'd8;

    logic [3:0]  phase_reg, phase_next;
    logic [7:0]  sum_reg, sum_next;
    logic [15:0] dist_reg, dist_next;
    logic [15:0] str_reg, str_next;
    logic [15:0] temp_reg, temp_next;
    logic        out_full, out_push;
    lfp_result_t frame;

    // only the checksum byte needs room in the result queue
    assign item_take = item_valid && ((phase_reg != PH_CKSUM) || !out_full);
    assign out_push  = item_take && (phase_reg == PH_CKSUM);

    always_comb
    begin
        frame.distance            = dist_reg;
        frame.strength            = str_reg;
        frame.temperature_eighths = signed'({1'b0, temp_reg} - TEMP_OFFSET);
        frame.checksum_ok         = (item.data == sum_reg);
    end

    always_comb
    begin
        phase_next = phase_reg;
        sum_next   = sum_reg;
        dist_next  = dist_reg;
        str_next   = str_reg;
        temp_next  = temp_reg;
        if (item_take)
        begin
            sum_next   = sum_reg + item.data;
            phase_next = phase_reg + 1'b1;
            unique case (phase_reg)
                PH_HDR2:
                begin
                    phase_next = item.is_header ? PH_DIST_LO : PH_HUNT;
                end
                PH_DIST_LO: dist_next[7:0]  = item.data;
                PH_DIST_HI: dist_next[15:8] = item.data;
                PH_STR_LO:  str_next[7:0]   = item.data;
                PH_STR_HI:  str_next[15:8]  = item.data;
                PH_TEMP_LO: temp_next[7:0]  = item.data;
                PH_TEMP_HI: temp_next[15:8] = item.data;
                PH_CKSUM:
                begin
                    phase_next = PH_HUNT;
                end
                default:
                begin
                    // hunting; stray phase codes hunt too
                    sum_next   = item.data;
                    phase_next = item.is_header ? PH_HDR2 : PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            sum_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
        str_reg  <= str_next;
        temp_reg <= temp_next;
    end

    logic out_empty;

    lfp_fifo #(
        .WIDTH ($bits(lfp_result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_push),
        .wr_data (frame),
        .full    (out_full),
        .rd_en   (pop),
        .rd_data (result),
        .empty   (out_empty)
    );

    assign empty = out_empty;

    a_push_only_at_cksum: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> (phase_reg == PH_CKSUM) && !out_full)
        else $error("result written outside checksum phase");

    a_phase_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PH_CKSUM)
        else $error("frame phase out of range");

    a_frame_end_hunts: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |=> phase_reg == PH_HUNT)
        else $error("no return to hunting after frame end");

    a_bad_hdr2_hunts: assert property (@(posedge clk) disable iff (!rst_n)
        item_take && (phase_reg == PH_HDR2) && !item.is_header |=> phase_reg == PH_HUNT)
        else $error("missing second header did not restart hunt");

endmodule
